// ===== design/direct_mapped_hash_table_assert.svh =====
// Assertion macros used by the checker file
`ifndef DIRECT_MAPPED_HASH_TABLE_ASSERT_SVH
`define DIRECT_MAPPED_HASH_TABLE_ASSERT_SVH

// Clocked check, muted while reset is high
`define DMHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds through reset
`define DMHT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/dmht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dmht_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

  // Operation codes
  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [63:0]        key;
    logic [5:0]         from_square;
    logic [5:0]         to_square;
    logic [2:0]         promotion_kind;
    logic [2:0]         move_kind;
    logic signed [15:0] eval_score;
    logic [7:0]         search_depth;
    logic [1:0]         bound_kind;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [5:0]         found_from;
    logic [5:0]         found_to;
    logic [2:0]         found_promotion;
    logic [2:0]         found_flag;
    logic signed [15:0] found_score;
    logic [7:0]         found_depth;
    logic [1:0]         found_bound;
  } rsp_t;

  // One table slot
  typedef struct packed {
    logic [63:0] key;
    logic [2:0]  flag;
    logic [2:0]  promotion;
    logic [5:0]  to_sq;
    logic [5:0]  from_sq;
    logic [15:0] score;
    logic [7:0]  depth;
    logic [1:0]  bound;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // request accepted: read slot, latch key
    logic store;       // write the request into its slot
    logic wipe_step;   // zero one slot of the sweep
    logic load_result; // fill the response register
    logic probe;       // request in flight is a probe
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic wipe_done;   // sweep is on its last slot
  } status_t;

endpackage

`default_nettype wire

// ===== design/dmht_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface dmht_req_if
  import dmht_pkg::*;
;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dmht_rsp_if
  import dmht_pkg::*;
;
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/dmht_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmht_ctrl
  import dmht_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_func,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire status_t    status,
  output cmd_t            cmd
);

  typedef enum logic [1:0] {
    ST_WIPE,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t     state;
  logic [1:0] op_q;
  logic       accept;

  // Result register must be empty, or emptying, by the lookup cycle
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.capture     = accept;
    cmd.store       = accept && (in_func == OP_STORE);
    cmd.wipe_step   = (state == ST_WIPE);
    cmd.load_result = (state == ST_LOOKUP);
    cmd.probe       = (state == ST_LOOKUP) && (op_q == OP_PROBE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WIPE;
      out_valid <= 1'b0;
      op_q      <= OP_PROBE;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_WIPE: begin
          if (status.wipe_done) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_q  <= in_func;
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          out_valid <= 1'b1;
          state     <= (op_q == OP_CLEAR) ? ST_WIPE : ST_IDLE;
        end
        default: begin
          state <= ST_WIPE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/dmht_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmht_datapath
  import dmht_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  output status_t   status,
  input  wire req_t req,
  output rsp_t      rsp
);

  localparam int unsigned SLOT_COUNT = 2 ** IDX_W;

  entry_t           mem [SLOT_COUNT];
  entry_t           rd_entry;
  logic [63:0]      key_q;
  logic [IDX_W-1:0] wipe_addr;
  logic [IDX_W-1:0] slot;
  entry_t           wr_entry;
  logic             match;

  assign slot          = req.key[IDX_W-1:0];
  assign status.wipe_done = &wipe_addr;

  always_comb begin
    wr_entry.key       = req.key;
    wr_entry.flag      = req.move_kind;
    wr_entry.promotion = req.promotion_kind;
    wr_entry.to_sq     = req.to_square;
    wr_entry.from_sq   = req.from_square;
    wr_entry.score     = req.eval_score;
    wr_entry.depth     = req.search_depth;
    wr_entry.bound     = req.bound_kind;
  end

  // Sweep pointer; wraps back to zero after the last slot
  always_ff @(posedge clk) begin
    if (rst) begin
      wipe_addr <= '0;
    end else if (cmd.wipe_step) begin
      wipe_addr <= wipe_addr + 1'b1;
    end
  end

  // Slot store, one write port and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wipe_step) begin
      mem[wipe_addr] <= '0;
    end else if (cmd.store) begin
      mem[slot] <= wr_entry;
    end
    if (cmd.capture) begin
      rd_entry <= mem[slot];
      key_q    <= req.key;
    end
  end

  assign match = cmd.probe && (rd_entry.key == key_q);

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      rsp.hit <= match;
      if (match) begin
        rsp.found_from      <= rd_entry.from_sq;
        rsp.found_to        <= rd_entry.to_sq;
        rsp.found_promotion <= rd_entry.promotion;
        rsp.found_flag      <= rd_entry.flag;
        rsp.found_score     <= rd_entry.score;
        rsp.found_depth     <= rd_entry.depth;
        rsp.found_bound     <= rd_entry.bound;
      end else begin
        rsp.found_from      <= '0;
        rsp.found_to        <= '0;
        rsp.found_promotion <= '0;
        rsp.found_flag      <= '0;
        rsp.found_score     <= '0;
        rsp.found_depth     <= '0;
        rsp.found_bound     <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/direct_mapped_hash_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Carries
// --------  ---  ----------------------------------------------------------
// req       in   request: func, key and entry data for a store
// rsp       out  one response per request: hit and the stored fields
//
// Probe, store and unused code: accept in idle, then one registered read
// of the slot memory and the key compare in the lookup state.
// Clear: the same steps for the response, then a sweep of all 1024 slots (one
// slot per cycle through the single write port) before the next request.
// After reset the same sweep runs with req.ready low.
// A stalled response holds; a new request is taken as soon as it leaves.

module direct_mapped_hash_table
  import dmht_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  dmht_req_if.sink    req,
  dmht_rsp_if.source  rsp
);

  cmd_t    cmd;
  status_t status;

  // Sequencing: sweep, idle, lookup
  dmht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_func   (req.data.func),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Slot memory, sweep pointer, compare and response register
  dmht_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .req    (req.data),
    .rsp    (rsp.data)
  );

endmodule

`default_nettype wire

// ===== design/dmht_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "direct_mapped_hash_table_assert.svh"

module dmht_checker
  import dmht_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire req_t req_data,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp_data
);

  logic       req_acc;
  logic [1:0] last_func;

  assign req_acc = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_func <= OP_PROBE;
    end else if (req_acc) begin
      last_func <= req_data.func;
    end
  end

  `DMHT_ASSERT(a_rsp_hold,
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data),
    "response dropped or changed while stalled")
  `DMHT_ASSERT(a_rsp_two_cycles,
    req_acc |-> ##2 rsp_valid,
    "no response two cycles after request")
  `DMHT_ASSERT(a_busy_after_acc,
    req_acc |=> !req_ready,
    "request taken while one in flight")
  `DMHT_ASSERT(a_hit_only_probe,
    rsp_valid && rsp_data.hit |-> last_func == OP_PROBE,
    "hit on a non-probe request")
  // Everything below the hit bit must be zero on a miss
  `DMHT_ASSERT(a_miss_zero,
    rsp_valid && !rsp_data.hit |-> rsp_data[$bits(rsp_t)-2:0] == '0,
    "miss with non-zero fields")

endmodule

bind direct_mapped_hash_table dmht_checker u_dmht_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_data  (req.data),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import dmht_pkg::*;

  // Code 3 is not decoded by the block: it must leave the table alone and answer zero
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Cycles with no handshake on either side before the run is declared hung.
  // Worst honest case is the 1024-slot sweep after reset or a clear, plus a
  // few cycles of sender gap and receiver stall, so this is several times over.
  localparam int unsigned HANG_LIMIT = 6000;

  // Quiet cycles after the last response, to catch stray responses
  localparam int unsigned TAIL_CYCLES = 16;

  localparam int unsigned RANDOM_REQUESTS = 1330;
  localparam int unsigned KEY_POOL_DEPTH  = 32;

  logic clk = 1'b0;
  logic rst;

  dmht_req_if req_ch ();
  dmht_rsp_if rsp_ch ();

  direct_mapped_hash_table i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the table and the responses still owed by the block
  // ---------------------------------------------------------------------------
  entry_t      shadow_slots [TABLE_ENTRIES];
  rsp_t        owed_responses [$];
  logic [63:0] recent_keys [$];   // keys stored lately, so probes can hit

  // When low, both sides run flat out (no sender gaps, no receiver stalls)
  bit          idle_on = 1'b1;

  int unsigned failures   = 0;
  int unsigned n_requests = 0;
  int unsigned n_stores   = 0;
  int unsigned n_probes   = 0;
  int unsigned n_hits     = 0;
  int unsigned n_clears   = 0;
  int unsigned n_unused   = 0;

  // Applies one accepted request to the shadow table and returns the response
  // the block owes for it. Only a probe that matches the full 64-bit key
  // returns data; everything else answers with an all-zero response.
  function automatic rsp_t apply_to_shadow(input req_t r);
    rsp_t             res;
    logic [IDX_W-1:0] slot;
    res  = '0;
    slot = r.key[IDX_W-1:0];
    n_requests++;
    case (r.func)
      OP_PROBE: begin
        n_probes++;
        if (shadow_slots[slot].key == r.key) begin
          n_hits++;
          res.hit             = 1'b1;
          res.found_from      = shadow_slots[slot].from_sq;
          res.found_to        = shadow_slots[slot].to_sq;
          res.found_promotion = shadow_slots[slot].promotion;
          res.found_flag      = shadow_slots[slot].flag;
          res.found_score     = shadow_slots[slot].score;
          res.found_depth     = shadow_slots[slot].depth;
          res.found_bound     = shadow_slots[slot].bound;
        end
      end
      OP_STORE: begin
        // Always-replace: whatever sat in the slot is gone
        n_stores++;
        shadow_slots[slot].key       = r.key;
        shadow_slots[slot].from_sq   = r.from_square;
        shadow_slots[slot].to_sq     = r.to_square;
        shadow_slots[slot].promotion = r.promotion_kind;
        shadow_slots[slot].flag      = r.move_kind;
        shadow_slots[slot].score     = r.eval_score;
        shadow_slots[slot].depth     = r.search_depth;
        shadow_slots[slot].bound     = r.bound_kind;
      end
      OP_CLEAR: begin
        // Next request is only taken after the sweep, so wiping at once is exact
        n_clears++;
        foreach (shadow_slots[i]) shadow_slots[i] = '0;
      end
      default: n_unused++;
    endcase
    return res;
  endfunction

  function automatic req_t make_request(
    input logic [1:0]         func,
    input logic [63:0]        key,
    input logic [5:0]         from_sq,
    input logic [5:0]         to_sq,
    input logic [2:0]         promotion,
    input logic [2:0]         flag,
    input logic signed [15:0] score,
    input logic [7:0]         depth,
    input logic [1:0]         bound
  );
    req_t r;
    r.func           = func;
    r.key            = key;
    r.from_square    = from_sq;
    r.to_square      = to_sq;
    r.promotion_kind = promotion;
    r.move_kind      = flag;
    r.eval_score     = score;
    r.search_depth   = depth;
    r.bound_kind     = bound;
    return r;
  endfunction

  // Same slot, different key: flips one bit above the index
  function automatic logic [63:0] slot_alias(input logic [63:0] key);
    return key ^ (64'd1 << $urandom_range(IDX_W, 63));
  endfunction

  // Mostly stores and probes over a small pool of live keys, so that hits,
  // replacements and same-slot misses all turn up often; clears are rare as
  // each one costs a full sweep.
  function automatic req_t random_request();
    req_t        r;
    logic [31:0] rnd;
    int unsigned pick;
    int unsigned sub;
    rnd              = $urandom;
    r.func           = OP_PROBE;
    r.key            = {$urandom, $urandom};
    r.from_square    = rnd[5:0];
    r.to_square      = rnd[11:6];
    r.promotion_kind = rnd[14:12];
    r.move_kind      = rnd[17:15];
    r.bound_kind     = rnd[19:18];
    r.search_depth   = rnd[27:20];
    rnd              = $urandom;
    r.eval_score     = rnd[15:0];
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 19);
    if (pick < 46) begin
      r.func = OP_STORE;
      if (recent_keys.size() > 0 && sub < 5)
        r.key = slot_alias(recent_keys[$urandom_range(0, recent_keys.size() - 1)]);
      recent_keys.push_back(r.key);
      if (recent_keys.size() > KEY_POOL_DEPTH) void'(recent_keys.pop_front());
    end else if (pick < 97) begin
      if (recent_keys.size() > 0 && sub < 12)
        r.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      else if (recent_keys.size() > 0 && sub < 16)
        r.key = slot_alias(recent_keys[$urandom_range(0, recent_keys.size() - 1)]);
      else if (sub == 16)
        r.key = '0;
    end else if (pick < 98) begin
      r.func = OP_CLEAR;
      recent_keys.delete();
    end else begin
      r.func = OP_UNUSED;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Valid is only lowered when a gap is drawn, so back-to-back requests keep
  // it high across the handshake edge. Ready is read at the edge, i.e. the
  // value the block saw, and the expected response is queued on acceptance.
  task automatic send_request(input req_t r);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    owed_responses.push_back(apply_to_shadow(r));
  endtask

  // Sender holds off until the block has answered everything
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    while (owed_responses.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random stalls on ready, and the check of every response
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  initial begin : response_side
    int unsigned stall;
    rsp_t        want;
    rsp_t        got;
    stall = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (owed_responses.size() == 0) begin
          $error("response with no request outstanding: %0h", got);
          failures++;
        end else begin
          want = owed_responses.pop_front();
          check_field("hit",             64'(want.hit),             64'(got.hit));
          check_field("found_from",      64'(want.found_from),      64'(got.found_from));
          check_field("found_to",        64'(want.found_to),        64'(got.found_to));
          check_field("found_promotion", 64'(want.found_promotion), 64'(got.found_promotion));
          check_field("found_flag",      64'(want.found_flag),      64'(got.found_flag));
          check_field("found_score",     64'(want.found_score),     64'(got.found_score));
          check_field("found_depth",     64'(want.found_depth),     64'(got.found_depth));
          check_field("found_bound",     64'(want.found_bound),     64'(got.found_bound));
        end
        stall = idle_on ? $urandom_range(0, 4) : 0;
        rsp_ch.ready <= (stall == 0);
      end else if (stall > 0) begin
        stall--;
        rsp_ch.ready <= (stall == 0);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Hang detector: counts cycles in which neither channel moves anything
  initial begin : hang_watch
    int unsigned quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no request or response moved for %0d cycles", HANG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Table is zero after reset: key 0 hits slot 0's zero key with zero
  // data, any other key misses, including one that lands on slot 0.
  task automatic test_fresh_table();
    send_request(make_request(OP_PROBE, 64'd0, 6'd0, 6'd0, 3'd0, 3'd0, 16'sd0, 8'd0, 2'd0));
    send_request(make_request(OP_PROBE, 64'd1, 6'd0, 6'd0, 3'd0, 3'd0, 16'sd0, 8'd0, 2'd0));
    send_request(make_request(OP_PROBE, '1, 6'd63, 6'd63, 3'd7, 3'd7, 16'sd0, 8'd0, 2'd0));
    send_request(make_request(OP_PROBE, 64'd1 << IDX_W, 6'd0, 6'd0, 3'd0, 3'd0, 16'sd0,
                              8'd0, 2'd0));
  endtask

  // Field extremes through a store and back out through a probe. The store on
  // slot 0 also knocks out the zero key that key 0 used to hit.
  task automatic test_store_extremes();
    send_request(make_request(OP_STORE, '1, 6'd63, 6'd63, 3'd7, 3'd7, 16'sh7fff, 8'd255,
                              2'd3));
    send_request(make_request(OP_PROBE, '1, 6'd0, 6'd0, 3'd0, 3'd0, 16'sd0, 8'd0, 2'd0));
    send_request(make_request(OP_STORE, 64'h8000_0000_0000_0000, 6'd0, 6'd0, 3'd0, 3'd0,
                              16'sh8000, 8'd0, 2'd0));
    send_request(make_request(OP_PROBE, 64'h8000_0000_0000_0000, 6'd63, 6'd63, 3'd7, 3'd7,
                              16'sh7fff, 8'd255, 2'd3));
    send_request(make_request(OP_PROBE, 64'd0, 6'd0, 6'd0, 3'd0, 3'd0, 16'sd0, 8'd0, 2'd0));
  endtask

  // Two keys sharing a slot: the later store wins, the earlier key now misses
  task automatic test_always_replace();
    send_request(make_request(OP_STORE, 64'h0123_4567_89ab_c155, 6'd12, 6'd28, 3'd0, 3'd1,
                              16'sd150, 8'd6, 2'd1));
    send_request(make_request(OP_STORE, 64'h0123_4667_89ab_c155, 6'd52, 6'd36, 3'd4, 3'd5,
                              -16'sd900, 8'd11, 2'd2));
    send_request(make_request(OP_PROBE, 64'h0123_4567_89ab_c155, 6'd0, 6'd0, 3'd0, 3'd0,
                              16'sd0, 8'd0, 2'd0));
    send_request(make_request(OP_PROBE, 64'h0123_4667_89ab_c155, 6'd0, 6'd0, 3'd0, 3'd0,
                              16'sd0, 8'd0, 2'd0));
  endtask

  // The undecoded code carries store-like data; the slot must be untouched
  task automatic test_unused_code();
    send_request(make_request(OP_UNUSED, 64'h0123_4667_89ab_c155, 6'd1, 6'd2, 3'd3, 3'd4,
                              16'sd5, 8'd6, 2'd3));
    send_request(make_request(OP_PROBE, 64'h0123_4667_89ab_c155, 6'd0, 6'd0, 3'd0, 3'd0,
                              16'sd0, 8'd0, 2'd0));
  endtask

  // Clear sweeps every slot back to zero: stored keys miss, key 0 hits again
  task automatic test_clear_table();
    send_request(make_request(OP_CLEAR, '1, 6'd63, 6'd63, 3'd7, 3'd7, 16'sh7fff, 8'd255,
                              2'd3));
    send_request(make_request(OP_PROBE, '1, 6'd0, 6'd0, 3'd0, 3'd0, 16'sd0, 8'd0, 2'd0));
    send_request(make_request(OP_PROBE, 64'd0, 6'd0, 6'd0, 3'd0, 3'd0, 16'sd0, 8'd0, 2'd0));
    send_request(make_request(OP_PROBE, 64'h0123_4667_89ab_c155, 6'd0, 6'd0, 3'd0, 3'd0,
                              16'sd0, 8'd0, 2'd0));
  endtask

  // Random traffic in stretches: mostly with gaps and stalls, every third
  // stretch flat out. Halfway through the sender waits for a full drain.
  task automatic test_random_traffic(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 150 == 0) idle_on = ((i / 150) % 3 != 2);
      if (i == count / 2) drain_responses();
      send_request(random_request());
    end
  endtask

  initial begin : stimulus
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_fresh_table();
    test_store_extremes();
    test_always_replace();
    test_unused_code();
    test_clear_table();
    test_random_traffic(RANDOM_REQUESTS);

    drain_responses();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_responses.size() != 0) begin
      $error("%0d responses never arrived", owed_responses.size());
      failures++;
    end

    $display("Ran %0d requests: %0d stores, %0d probes (%0d hits), %0d clears,",
             n_requests, n_stores, n_probes, n_hits, n_clears);
    $display("%0d with the undecoded code; sender gaps and receiver stalls of 0..4 cycles.",
             n_unused);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", failures);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
